FILE: sv/efcrc8_pkg.sv
// ----------------------------------------------------------------------------
// efcrc8_pkg
// Shared types, codes and the byte-wide crc-8 update for the frame encoder.
// ----------------------------------------------------------------------------
package efcrc8_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // header overheads: length byte counts type, addresses and crc
    localparam logic [BYTE_W:0] LEN_OVERHEAD   = 9'd4;
    localparam logic [BYTE_W:0] FRAME_OVERHEAD = 9'd6;

    localparam logic [BYTE_W-1:0] CRC_MSB_MASK = 8'h80;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_CRC_POLY  = 8'd213;
    localparam logic [BYTE_W-1:0] RST_MAX_LEN   = 8'd62;
    localparam logic [BYTE_W-1:0] RST_MAX_FRAME = 8'd64;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_POLY  = 2'd0,
        CFG_MAX_LEN   = 2'd1,
        CFG_MAX_FRAME = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LEN_BIG   = 2'd1,
        ST_FRAME_BIG = 2'd2,
        ST_CAP_SMALL = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] crc_poly;
        logic [BYTE_W-1:0] max_len;
        logic [BYTE_W-1:0] max_frame;
    } t_cfg;

    // msb-first crc-8 over one byte
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_MSB_MASK) != '0) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/extended_frame_crc8_encoder_unit.sv
// ----------------------------------------------------------------------------
// extended_frame_crc8_encoder_unit
// Extended serial frame builder with crc-8 trailer, one byte per cycle out unless stalled.
// ----------------------------------------------------------------------------
// A start transfer (operation 0) is checked against the length and frame
// limits and the receiver capacity; a failure gives a single error result,
// otherwise the five header bytes go out one per cycle while the output is
// free (sync, length, type, destination, origin), plus the crc byte straight
// away when the payload is empty. Each payload transfer (operation 1) inside
// a frame gives its byte back, and the last one is followed by the crc over
// type, addresses and payload. Payload transfers outside a frame are dropped.
// Flow: the output channel moves one result per cycle while not stalled, so
// a start holds the input until its header bytes (and the crc with an empty
// payload) or its error result are emitted, and the last payload byte holds
// it until its crc is emitted. A single output register decouples the sides:
// the next transfer is taken while the last result of the previous one still
// waits downstream. The crc is updated one byte per cycle while the output is
// not stalled by an unrolled byte-wide step, type and address bytes included.
// Configuration writes are always ready and should only happen while idle.
// ----------------------------------------------------------------------------
module extended_frame_crc8_encoder_unit
    import efcrc8_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // input item channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [BYTE_W-1:0]    i_sync_byte,
    input  logic [BYTE_W-1:0]    i_frame_type,
    input  logic [BYTE_W-1:0]    i_dest_address,
    input  logic [BYTE_W-1:0]    i_source_address,
    input  logic [BYTE_W-1:0]    i_payload_length,
    input  logic [BYTE_W-1:0]    i_buffer_capacity,
    input  logic [BYTE_W-1:0]    i_data_byte,

    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_last_of_run,
    output logic [1:0]           o_status,
    output logic [BYTE_W-1:0]    o_frame_bytes,

    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    // emit sequencer, one result per step
    typedef enum logic [5:0] {
        S_FIRST = 6'b000001,   // sync byte / error / payload byte
        S_LEN   = 6'b000010,
        S_TYPE  = 6'b000100,
        S_DEST  = 6'b001000,
        S_ORIG  = 6'b010000,
        S_CRC   = 6'b100000
    } t_state;

    t_cfg w_cfg;

    // ---- configuration ----
    assign o_cfg_ready = 1'b1;

    efcrc8_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ---- input register ----
    logic              r_in_valid;
    t_op               r_op;
    logic [BYTE_W-1:0] r_sync;
    logic [BYTE_W-1:0] r_type;
    logic [BYTE_W-1:0] r_dest;
    logic [BYTE_W-1:0] r_orig;
    logic [BYTE_W-1:0] r_plen;
    logic [BYTE_W-1:0] r_cap;
    logic [BYTE_W-1:0] r_data;

    // ---- frame state ----
    t_state            r_state,     n_state;
    logic [BYTE_W-1:0] r_crc,       n_crc;
    logic [BYTE_W-1:0] r_remaining, n_remaining;
    logic              r_in_frame,  n_in_frame;
    logic [BYTE_W-1:0] r_total,     n_total;

    // ---- output register ----
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    t_status           r_out_status;
    logic [BYTE_W-1:0] r_out_total;

    logic              out_free;
    logic              emit;
    logic              item_done;
    logic              in_accept;
    logic [BYTE_W-1:0] n_out_byte;
    logic              n_out_last;
    t_status           n_out_status;
    logic [BYTE_W-1:0] n_out_total;

    logic [BYTE_W:0]   len_field;
    logic [BYTE_W:0]   frame_size;
    t_status           check_status;

    // output register frees up when empty or its result is taken
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !item_done;
    assign in_accept = i_valid && !o_stall;

    // limit checks on the held start transfer, first failure wins
    assign len_field  = {1'b0, r_plen} + LEN_OVERHEAD;
    assign frame_size = {1'b0, r_plen} + FRAME_OVERHEAD;

    always_comb begin
        if (len_field > {1'b0, w_cfg.max_len}) begin
            check_status = ST_LEN_BIG;
        end else if (frame_size > {1'b0, w_cfg.max_frame}) begin
            check_status = ST_FRAME_BIG;
        end else if ({1'b0, r_cap} < frame_size) begin
            check_status = ST_CAP_SMALL;
        end else begin
            check_status = ST_OK;
        end
    end

    // sequencer: one result per step while the output register is free
    always_comb begin
        n_state      = r_state;
        n_crc        = r_crc;
        n_remaining  = r_remaining;
        n_in_frame   = r_in_frame;
        n_total      = r_total;
        emit         = 1'b0;
        item_done    = 1'b0;
        n_out_byte   = '0;
        n_out_last   = 1'b0;
        n_out_status = ST_OK;
        n_out_total  = r_total;

        if (r_in_valid) begin
            case (r_op)
                OP_START: begin
                    unique case (r_state)
                        S_FIRST: begin
                            if (out_free) begin
                                emit        = 1'b1;
                                n_in_frame  = 1'b0;
                                n_remaining = '0;
                                if (check_status != ST_OK) begin
                                    // single error result, block stays idle
                                    n_out_status = check_status;
                                    n_out_last   = 1'b1;
                                    n_out_total  = '0;
                                    item_done    = 1'b1;
                                end else begin
                                    n_out_byte  = r_sync;
                                    n_out_total = frame_size[BYTE_W-1:0];
                                    n_total     = frame_size[BYTE_W-1:0];
                                    n_crc       = '0;
                                    n_state     = S_LEN;
                                end
                            end
                        end
                        S_LEN: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = len_field[BYTE_W-1:0];
                                n_state    = S_TYPE;
                            end
                        end
                        S_TYPE: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = r_type;
                                n_crc      = crc8_update(r_crc, r_type, w_cfg.crc_poly);
                                n_state    = S_DEST;
                            end
                        end
                        S_DEST: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = r_dest;
                                n_crc      = crc8_update(r_crc, r_dest, w_cfg.crc_poly);
                                n_state    = S_ORIG;
                            end
                        end
                        S_ORIG: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = r_orig;
                                n_crc      = crc8_update(r_crc, r_orig, w_cfg.crc_poly);
                                if (r_plen != '0) begin
                                    // payload follows: open the frame
                                    n_out_last  = 1'b1;
                                    n_remaining = r_plen;
                                    n_in_frame  = 1'b1;
                                    item_done   = 1'b1;
                                    n_state     = S_FIRST;
                                end else begin
                                    // empty payload: crc goes out next
                                    n_state = S_CRC;
                                end
                            end
                        end
                        S_CRC: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = r_crc;
                                n_out_last = 1'b1;
                                item_done  = 1'b1;
                                n_state    = S_FIRST;
                            end
                        end
                        default: begin
                            n_state = S_FIRST;
                        end
                    endcase
                end
                OP_DATA: begin
                    unique case (r_state)
                        S_FIRST: begin
                            if (!r_in_frame || r_remaining == '0) begin
                                // stray payload byte, dropped
                                n_in_frame = 1'b0;
                                item_done  = 1'b1;
                            end else if (out_free) begin
                                emit        = 1'b1;
                                n_out_byte  = r_data;
                                n_crc       = crc8_update(r_crc, r_data, w_cfg.crc_poly);
                                n_remaining = r_remaining - 8'd1;
                                if (r_remaining != 8'd1) begin
                                    n_out_last = 1'b1;
                                    item_done  = 1'b1;
                                end else begin
                                    // last payload byte: close frame, crc next
                                    n_in_frame = 1'b0;
                                    n_state    = S_CRC;
                                end
                            end
                        end
                        S_CRC: begin
                            if (out_free) begin
                                emit       = 1'b1;
                                n_out_byte = r_crc;
                                n_out_last = 1'b1;
                                item_done  = 1'b1;
                                n_state    = S_FIRST;
                            end
                        end
                        S_LEN, S_TYPE, S_DEST, S_ORIG: begin
                            n_state = S_FIRST;
                        end
                        default: begin
                            n_state = S_FIRST;
                        end
                    endcase
                end
                default: begin
                    item_done = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= S_FIRST;
            r_crc       <= '0;
            r_remaining <= '0;
            r_in_frame  <= 1'b0;
            r_total     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (item_done) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= emit || (r_out_valid && i_stall);
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_in_frame  <= n_in_frame;
            r_total     <= n_total;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= t_op'(i_operation);
            r_sync <= i_sync_byte;
            r_type <= i_frame_type;
            r_dest <= i_dest_address;
            r_orig <= i_source_address;
            r_plen <= i_payload_length;
            r_cap  <= i_buffer_capacity;
            r_data <= i_data_byte;
        end
        if (emit) begin
            r_out_byte   <= n_out_byte;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
            r_out_total  <= n_out_total;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_status      = r_out_status;
    assign o_frame_bytes = r_out_total;

`ifndef NO_ASSERTIONS
    // an open frame always has payload bytes still to come
    a_frame_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> r_remaining != '0)
        else $error("open frame with no remaining payload");

    // an error result is alone: last of its run, no frame size
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_last && r_out_total == '0))
        else $error("error result carries frame data");

    // an error leaves no frame open behind it
    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> !r_in_frame)
        else $error("frame open after error result");

    // a held item that needs the output waits while the output is stalled
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall && r_state != S_FIRST) |-> o_stall)
        else $error("item released while output stalled");

    // mid-sequence states only exist while an item is held
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIRST) |-> r_in_valid)
        else $error("sequencer active without an item");
`endif

endmodule

FILE: sv/efcrc8_cfg.sv
// ----------------------------------------------------------------------------
// efcrc8_cfg
// Configuration register file: polynomial and the two frame limits.
// ----------------------------------------------------------------------------
module efcrc8_cfg
    import efcrc8_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CRC_POLY:  n_cfg.crc_poly  = i_cfg_data;
                CFG_MAX_LEN:   n_cfg.max_len   = i_cfg_data;
                CFG_MAX_FRAME: n_cfg.max_frame = i_cfg_data;
                default:       n_cfg = r_cfg; // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_poly  <= RST_CRC_POLY;
            r_cfg.max_len   <= RST_MAX_LEN;
            r_cfg.max_frame <= RST_MAX_FRAME;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
